// ===== design/assert_macros.svh =====
// Assertion macros shared by the plotter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define AST_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define AST_PROP(label, clk, rst_n, prop, msg)
`define AST_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/scp_pkg.sv =====
// Shared types and constants of the strip chart column plotter
package scp_pkg;
	localparam int DISP_ROWS = 64;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 4;
	localparam int WORD_W    = 16;
	localparam int BIT_W     = 4;

	localparam logic [WORD_W-1:0] LEFT_PIXEL = 16'h8000;
	localparam logic [ROW_W:0]    LAST_ROW   = 7'h3F;
	localparam logic [COL_W-1:0]  LOWER_COL  = 4'h8;
	localparam logic [BIT_W-1:0]  RIGHT_BIT  = 4'hF;

	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_LOW  = 2'd1,
		CLAMP_HIGH = 2'd2
	} clamp_t;

	typedef struct packed {
		logic              valid;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [WORD_W-1:0] mask;
		logic              set_bit;
		logic              last;
		clamp_t            status;
		logic              fresh;
	} issue_t;
endpackage

// ===== design/scp_store.sv =====
// Plot shadow store: one write port, one registered read port
module scp_store #(
	parameter int DEPTH = 384,
	parameter int AW    = 9
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             wa,
	input  logic [scp_pkg::WORD_W-1:0] wd,
	input  logic                      re,
	input  logic [AW-1:0]             ra,
	output logic [scp_pkg::WORD_W-1:0] rd
);
	import scp_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;
endmodule

// ===== design/scp_seq.sv =====
// Item intake, clamping and row sequencer that issues store reads
`include "assert_macros.svh"
module scp_seq #(
	parameter int WORD_COLUMNS = 8,
	parameter int PLOT_ROWS    = 48,
	parameter int AW           = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [7:0]   sample,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic                adv,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	output scp_pkg::issue_t     iss
);
	import scp_pkg::*;

	localparam int CW = (WORD_COLUMNS > 1) ? $clog2(WORD_COLUMNS) : 1;
	localparam int RW = (PLOT_ROWS > 1) ? $clog2(PLOT_ROWS) : 1;
	localparam logic [ROW_W-1:0]  FIRST_ROW = ROW_W'(DISP_ROWS - PLOT_ROWS);
	localparam logic [RW-1:0]     LAST_OFF  = RW'(PLOT_ROWS - 1);
	localparam logic [CW-1:0]     LAST_COL  = CW'(WORD_COLUMNS - 1);
	localparam logic [AW-1:0]     ROW_STEP  = AW'(PLOT_ROWS);
	localparam logic signed [7:0] MAX_H     = 8'(PLOT_ROWS - 1);

	logic                    busy_q;
	logic [RW-1:0]           off_q;
	logic [AW-1:0]           base_q;
	logic [CW-1:0]           col_q;
	logic [BIT_W-1:0]        bitpos_q;
	logic [ROW_W-1:0]        height_q;
	clamp_t                  status_q;
	logic [WORD_W-1:0]       mask_q;
	logic [WORD_COLUMNS-1:0] seen_q;

	logic             accept;
	logic             done;
	logic [BIT_W-1:0] bitpos_next;
	logic [ROW_W-1:0] row;
	logic [ROW_W:0]   row_sum;
	logic [ROW_W-1:0] height_in;
	clamp_t           status_in;

	assign done         = busy_q && adv && (off_q == LAST_OFF);
	assign sample_ready = !busy_q || done;
	assign accept       = sample_valid && sample_ready;
	assign bitpos_next  = done ? bitpos_q + 1'b1 : bitpos_q;

	always_comb begin
		if (sample < 0) begin
			height_in = '0;
			status_in = CLAMP_LOW;
		end else if (sample > MAX_H) begin
			height_in = ROW_W'(MAX_H);
			status_in = CLAMP_HIGH;
		end else begin
			height_in = sample[ROW_W-1:0];
			status_in = CLAMP_NONE;
		end
	end

	assign row     = FIRST_ROW + ROW_W'(off_q);
	assign row_sum = {1'b0, row} + {1'b0, height_q};
	assign rd_en   = busy_q && adv;
	assign rd_addr = base_q + AW'(off_q);

	always_comb begin
		iss         = '0;
		iss.valid   = rd_en;
		iss.row     = row;
		iss.col     = COL_W'(col_q);
		iss.mask    = mask_q;
		iss.set_bit = row_sum > LAST_ROW;
		iss.last    = off_q == LAST_OFF;
		iss.status  = status_q;
		iss.fresh   = !seen_q[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			off_q    <= '0;
			base_q   <= '0;
			col_q    <= '0;
			bitpos_q <= '0;
			seen_q   <= '0;
			height_q <= '0;
			status_q <= CLAMP_NONE;
			mask_q   <= '0;
		end else begin
			if (accept) begin
				off_q <= '0;
			end else if (rd_en) begin
				off_q <= off_q + 1'b1;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				seen_q[col_q] <= 1'b1;
				bitpos_q      <= bitpos_next;
				if (bitpos_q == RIGHT_BIT) begin
					if (col_q == LAST_COL) begin
						col_q  <= '0;
						base_q <= '0;
					end else begin
						col_q  <= col_q + 1'b1;
						base_q <= base_q + ROW_STEP;
					end
				end
			end
			if (accept) begin
				height_q <= height_in;
				status_q <= status_in;
				mask_q   <= LEFT_PIXEL >> bitpos_next;
			end
		end
	end

	`AST_PROP(a_accept_start, clk, arst_n, accept |=> busy_q && off_q == '0, "item start lost")
	`AST_PROP(a_stall_hold, clk, arst_n, busy_q && !adv |=> $stable(off_q) && $stable(col_q), "row advanced on stall")
endmodule

// ===== design/scp_update.sv =====
// Read-modify-write stage with forwarding and the result register
`include "assert_macros.svh"
module scp_update #(
	parameter int AW = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scp_pkg::issue_t            iss,
	input  logic [AW-1:0]              rd_addr,
	input  logic [scp_pkg::WORD_W-1:0] rd_data,
	output logic                       adv,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [scp_pkg::WORD_W-1:0] wr_data,
	input  logic                       result_ready,
	output logic                       result_valid,
	output logic [4:0]                 gdram_row,
	output logic [3:0]                 gdram_col,
	output logic [15:0]                pixel_word,
	output logic                       last_write,
	output logic [1:0]                 clamp_status
);
	import scp_pkg::*;

	issue_t            iss_s2;
	logic [AW-1:0]     addr_s2;
	logic              fwd_s2;
	logic [WORD_W-1:0] fwd_word_s2;

	logic              out_valid_q;
	logic [4:0]        row_q;
	logic [COL_W-1:0]  col_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;
	clamp_t            status_q;

	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] new_word;

	assign adv = !out_valid_q || result_ready;

	always_comb begin
		if (fwd_s2) begin
			old_word = fwd_word_s2;
		end else if (iss_s2.fresh) begin
			old_word = '0;
		end else begin
			old_word = rd_data;
		end
		new_word = iss_s2.set_bit ? (old_word | iss_s2.mask) : (old_word & ~iss_s2.mask);
	end

	assign wr_en   = iss_s2.valid && adv;
	assign wr_addr = addr_s2;
	assign wr_data = new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s2      <= '0;
			addr_s2     <= '0;
			fwd_s2      <= 1'b0;
			fwd_word_s2 <= '0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			word_q      <= '0;
			last_q      <= 1'b0;
			status_q    <= CLAMP_NONE;
		end else if (adv) begin
			iss_s2      <= iss;
			addr_s2     <= rd_addr;
			fwd_s2      <= wr_en && iss.valid && (wr_addr == rd_addr);
			fwd_word_s2 <= new_word;
			out_valid_q <= iss_s2.valid;
			if (iss_s2.valid) begin
				row_q    <= iss_s2.row[4:0];
				col_q    <= iss_s2.row[5] ? iss_s2.col + LOWER_COL : iss_s2.col;
				word_q   <= new_word;
				last_q   <= iss_s2.last;
				status_q <= iss_s2.status;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign gdram_row    = row_q;
	assign gdram_col    = col_q;
	assign pixel_word   = word_q;
	assign last_write   = last_q;
	assign clamp_status = status_q;

	`AST_PROP(a_last_out, clk, arst_n, iss_s2.valid && iss_s2.last && adv |=> result_valid && last_write, "final row write not delivered")
	`AST_PROP(a_fwd_live, clk, arst_n, fwd_s2 |-> iss_s2.valid, "forward into an empty stage")
endmodule

// ===== design/strip_chart_column_plotter.sv =====
// Top level of the strip chart column plotter
// Each accepted sample is clamped to 0..PLOT_ROWS-1 and drawn as one bar
// pixel column: the block makes one read-modify-write of the shadow store
// per plotted row, top row first, and emits PLOT_ROWS results per item
// (48 by default), each with the split display row/column address. One
// store read per row sets the pace: one row per cycle while the result
// side does not stall; the next sample is taken in the cycle the last
// row is read. The first result passes the sequencer, update stage and
// result register; result stalls hold the whole row sequence. Column fill
// bits stand in for clearing the store, so it is usable right after reset.
module strip_chart_column_plotter #(
	parameter int WORD_COLUMNS = 8,
	parameter int PLOT_ROWS    = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic signed [7:0] sample,
	input  logic              sample_valid,
	output logic              sample_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [4:0]        gdram_row,
	output logic [3:0]        gdram_col,
	output logic [15:0]       pixel_word,
	output logic              last_write,
	output logic [1:0]        clamp_status
);
	import scp_pkg::*;

	localparam int DEPTH = WORD_COLUMNS * PLOT_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	issue_t            iss;
	logic              adv;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	scp_seq #(
		.WORD_COLUMNS(WORD_COLUMNS),
		.PLOT_ROWS   (PLOT_ROWS),
		.AW          (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.adv         (adv),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.iss         (iss)
	);

	scp_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk(clk),
		.we (wr_en),
		.wa (wr_addr),
		.wd (wr_data),
		.re (rd_en),
		.ra (rd_addr),
		.rd (rd_data)
	);

	scp_update #(
		.AW(AW)
	) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.iss         (iss),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.adv         (adv),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.gdram_row   (gdram_row),
		.gdram_col   (gdram_col),
		.pixel_word  (pixel_word),
		.last_write  (last_write),
		.clamp_status(clamp_status)
	);
endmodule
